// ===== rtl/pssp_pkg.sv =====
// Shared constants and types for the pendulum swing-up phase machine.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package pssp_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int ANGLE_W          = 15;
	localparam int ANGLE_MAG_W      = ANGLE_W - 1;
	localparam int SPEED_W          = 8;
	localparam int DRIVE_W          = 9;
	localparam int PHASE_W          = 2;
	localparam int DIR_W            = 2;
	localparam int OUT_DATA_W       = 16;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 8'd150;

	// Phase codes as they appear on phase_now
	localparam logic [PHASE_W-1:0] PH_INIT = 2'd0;
	localparam logic [PHASE_W-1:0] PH_DOWN = 2'd1;
	localparam logic [PHASE_W-1:0] PH_LOW  = 2'd2;
	localparam logic [PHASE_W-1:0] PH_HIGH = 2'd3;

	// Angle thresholds, Q3.12 radians
	localparam logic [ANGLE_MAG_W-1:0] ANG_BOTTOM   = 14'd12780; // |angle| >= 3.12
	localparam logic [ANGLE_MAG_W-1:0] ANG_NEAR_BOT = 14'd12288; // |angle| > 3.0
	localparam logic [ANGLE_MAG_W-1:0] ANG_HIGH     = 14'd8192;  // |angle| < 2.0

	// Rate thresholds, Q5.10 rad/s
	localparam logic [31:0] RATE_SLOW  = 32'd512;  // |rate| < 0.5
	localparam logic [31:0] RATE_STILL = 32'd51;   // |rate| < 0.05
	localparam logic [31:0] RATE_FAST  = 32'd2048; // |rate| > 2.0

	typedef struct packed {
		logic                      fire;
		logic signed [DRIVE_W-1:0] drive;
		logic [PHASE_W-1:0]        phase_now;
	} pssp_res_t;

endpackage

// ===== rtl/pssp_ctrl.sv =====
// Phase, drive direction and reversal lock of the swing-up controller.
// Computes one step from a registered sample; depends on pssp_pkg.
`timescale 1ns / 1ps

module pssp_ctrl
	import pssp_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           active,
	input  logic signed [ANGLE_W-1:0]      angle,
	input  logic signed [SAMPLE_WIDTH-1:0] rate,
	input  logic [SPEED_W-1:0]             max_speed,
	output pssp_res_t                      res
);

	typedef enum logic [DIR_W-1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BWD  = 2'd2,
		DIR_RSVD = 2'd3
	} dir_t;

	localparam logic signed [ANGLE_W-1:0]      ANG_MIN  = {1'b1, {(ANGLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] RATE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic [PHASE_W-1:0]      phase_q, phase_d;
	dir_t                    dir_q, dir_d;
	logic                    locked_q, locked_d;
	logic [ANGLE_MAG_W-1:0]  a_mag;
	logic [SAMPLE_WIDTH-2:0] r_mag;
	logic [31:0]             r_ext;
	logic                    fire;
	logic [DRIVE_W-1:0]      spd_ext;

	// Saturating magnitudes
	always_comb begin
		if (angle == ANG_MIN) begin
			a_mag = '1;
		end else if (angle[ANGLE_W-1]) begin
			a_mag = ANGLE_MAG_W'(-angle);
		end else begin
			a_mag = angle[ANGLE_MAG_W-1:0];
		end
		if (rate == RATE_MIN) begin
			r_mag = '1;
		end else if (rate[SAMPLE_WIDTH-1]) begin
			r_mag = (SAMPLE_WIDTH-1)'(-rate);
		end else begin
			r_mag = rate[SAMPLE_WIDTH-2:0];
		end
		r_ext = 32'(r_mag);
	end

	always_comb begin
		phase_d  = phase_q;
		dir_d    = dir_q;
		locked_d = locked_q;
		fire     = 1'b0;
		case (phase_q)
			PH_INIT: begin
				if (a_mag >= ANG_BOTTOM && r_ext < RATE_SLOW)
					phase_d = PH_DOWN;
			end
			PH_DOWN: begin
				if (a_mag < ANG_BOTTOM && r_ext <= RATE_STILL) begin
					phase_d = PH_LOW;
				end else begin
					dir_d = DIR_FWD;
					fire  = 1'b1;
				end
			end
			PH_LOW: begin
				if (a_mag < ANG_HIGH)
					phase_d = PH_HIGH;
				// push against the rate
				dir_d = (!rate[SAMPLE_WIDTH-1] && rate != '0) ? DIR_BWD : DIR_FWD;
				fire  = 1'b1;
			end
			default: begin
				if (a_mag < ANG_HIGH && r_ext < RATE_SLOW)
					locked_d = 1'b0;
				// reverse once per lap at the bottom
				if (a_mag > ANG_NEAR_BOT && r_ext > RATE_FAST && !locked_d) begin
					case (dir_q)
						DIR_FWD: dir_d = DIR_BWD;
						DIR_BWD: dir_d = DIR_FWD;
						default: dir_d = dir_q;
					endcase
					locked_d = 1'b1;
				end
				fire = (dir_d == DIR_FWD) || (dir_d == DIR_BWD);
			end
		endcase
	end

	assign spd_ext       = DRIVE_W'(max_speed);
	assign res.fire      = active && fire;
	assign res.drive     = (dir_d == DIR_FWD) ? signed'(spd_ext) : signed'(-spd_ext);
	assign res.phase_now = phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INIT;
			dir_q    <= DIR_NONE;
			locked_q <= 1'b1;
		end else if (step && active) begin
			phase_q  <= phase_d;
			dir_q    <= dir_d;
			locked_q <= locked_d;
		end
	end

endmodule

// ===== rtl/pendulum_swingup_phase_machine.sv =====
// Top level of the pendulum swing-up phase machine: input register,
// result register and max_speed register around pssp_ctrl; uses pssp_pkg.
`timescale 1ns / 1ps

// One sample is taken per clock unless a waiting result stalls the input.
// A sample goes into the input register, is stepped through the phase logic
// once the result register can take it and, if it issues a motor command,
// leaves through the result register; so the block sustains one sample per
// cycle as long as results are taken. While a result waits, one more
// sample is still accepted into the input register. Samples with tuser low
// change nothing and give no result. max_speed is written through the cfg
// channel, which is always ready; write it only while the block is idle.

module pendulum_swingup_phase_machine
	import pssp_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// angle [14:0], rate [14+SAMPLE_WIDTH:15], zero fill above
	input  logic [((ANGLE_W+SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	// swing_active [0]
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// drive [8:0], phase_now [10:9], zero fill above
	output logic [OUT_DATA_W-1:0]        m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [SPEED_W-1:0]           cfg_data
);

	logic                           valid_s1;
	logic                           active_s1;
	logic signed [ANGLE_W-1:0]      angle_s1;
	logic signed [SAMPLE_WIDTH-1:0] rate_s1;
	logic [SPEED_W-1:0]             max_speed_q;
	logic                           m_valid_q;
	logic [DRIVE_W-1:0]             drive_q;
	logic [PHASE_W-1:0]             phase_q;
	logic                           advance;
	pssp_res_t                      res;

	assign advance   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			m_valid_q   <= 1'b0;
			max_speed_q <= MAX_SPEED_RST;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (m_tready || !m_valid_q)
				m_valid_q <= advance && res.fire;
			if (cfg_valid)
				max_speed_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			active_s1 <= s_tuser;
			angle_s1  <= s_tdata[ANGLE_W-1:0];
			rate_s1   <= s_tdata[ANGLE_W+SAMPLE_WIDTH-1:ANGLE_W];
		end
		if (advance && res.fire) begin
			drive_q <= res.drive;
			phase_q <= res.phase_now;
		end
	end

	pssp_ctrl #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.active    (active_s1),
		.angle     (angle_s1),
		.rate      (rate_s1),
		.max_speed (max_speed_q),
		.res       (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-DRIVE_W-PHASE_W){1'b0}}, phase_q, drive_q};

endmodule

// ===== rtl/pssp_chk.sv =====
// Port-level checks for the pendulum swing-up phase machine, bound to the
// top level; depends on pssp_pkg and pendulum_swingup_phase_machine.
`timescale 1ns / 1ps

module pssp_chk
	import pssp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// no command is ever issued in the init phase
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DRIVE_W+PHASE_W-1:DRIVE_W] != PH_INIT)
		else $error("result item in init phase");

	// drive is plus or minus an 8-bit speed
	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DRIVE_W-1:0] != 9'h100)
		else $error("drive out of range");

	// with no result pending the input side is open
	a_ready: assert property (@(posedge clk)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result item during reset");

endmodule

bind pendulum_swingup_phase_machine pssp_chk u_pssp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/tb_pendulum_swingup_phase_machine.sv =====
// Self-checking testbench for pendulum_swingup_phase_machine: drives angle/rate samples
// over the stream port, predicts every motor command and compares it. Uses pssp_pkg.
`timescale 1ns / 1ps

module tb_pendulum_swingup_phase_machine;
	import pssp_pkg::*;

	localparam int RATE_W      = SAMPLE_WIDTH_DEF;
	localparam int IN_W        = ((ANGLE_W + RATE_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	// Swing thresholds on |angle| (Q3.12) and |rate| (Q5.10)
	localparam int ANG_AT_BOTTOM   = 12780;
	localparam int ANG_OFF_BOTTOM  = 12779;
	localparam int ANG_SWING_HIGH  = 8192;
	localparam int ANG_NEAR_BOTTOM = 12288;
	localparam int ANG_MAG_MAX     = (1 << (ANGLE_W - 1)) - 1;
	localparam int RATE_SLOW_LIM   = 512;
	localparam int RATE_STILL_MAX  = 51;
	localparam int RATE_FAST_LIM   = 2048;
	localparam int RATE_MAG_MAX    = (1 << (RATE_W - 1)) - 1;

	typedef enum logic [DIR_W-1:0] {DIR_NONE, DIR_FWD, DIR_BWD} push_dir_e;
	typedef enum int {READY_ALWAYS, READY_COIN, READY_ONE_IN_THREE, READY_HOLD} stall_e;

	typedef struct {
		logic [DRIVE_W-1:0] drive;
		logic [PHASE_W-1:0] phase;
	} motor_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [SPEED_W-1:0]    cfg_data = '0;

	// Shadow of the block state
	logic [SPEED_W-1:0] speed_shadow = MAX_SPEED_RST;
	logic [PHASE_W-1:0] phase_shadow = PH_INIT;
	push_dir_e          dir_shadow = DIR_NONE;
	logic               locked_shadow = 1'b1;

	motor_cmd_t pending_cmds[$];

	int error_count = 0;
	int sent_count = 0;
	int cmd_count = 0;
	int reversal_count = 0;
	int speed_writes = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_tick = 0;
	stall_e stall_mode = READY_ALWAYS;

	pendulum_swingup_phase_machine #(
		.SAMPLE_WIDTH(RATE_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d commands still expected", $time, pending_cmds.size());
			$display("tb_pendulum_swingup_phase_machine NOT OK");
			$finish;
		end
	end

	// Receiver back-pressure: switch between ready patterns in stretches
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_e'($urandom_range(0, 3));
			stall_left = (stall_mode == READY_HOLD) ? $urandom_range(1, 10)
				: $urandom_range(5, 40);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
		READY_ALWAYS: begin
			m_tready <= 1'b1;
		end
		READY_COIN: begin
			m_tready <= 1'($urandom_range(0, 1));
		end
		READY_ONE_IN_THREE: begin
			m_tready <= (stall_tick % 3 == 0);
		end
		default: begin
			m_tready <= 1'b0;
		end
		endcase
	end

	// Compare each command leaving the block with the oldest prediction
	always @(posedge clk) begin
		motor_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected command, got drive %0d phase %0d", $time,
					$signed(m_tdata[DRIVE_W-1:0]), m_tdata[DRIVE_W+PHASE_W-1:DRIVE_W]);
				error_count++;
			end else begin
				want = pending_cmds.pop_front();
				cmd_count++;
				if (m_tdata[DRIVE_W-1:0] !== want.drive) begin
					$display("%0t: drive expected %0d got %0d", $time,
						$signed(want.drive), $signed(m_tdata[DRIVE_W-1:0]));
					error_count++;
				end
				if (m_tdata[DRIVE_W+PHASE_W-1:DRIVE_W] !== want.phase) begin
					$display("%0t: phase_now expected %0d got %0d", $time,
						want.phase, m_tdata[DRIVE_W+PHASE_W-1:DRIVE_W]);
					error_count++;
				end
				if (m_tdata[OUT_DATA_W-1:DRIVE_W+PHASE_W] !== '0) begin
					$display("%0t: tdata fill expected 0 got %0h", $time,
						m_tdata[OUT_DATA_W-1:DRIVE_W+PHASE_W]);
					error_count++;
				end
			end
		end
	end

	// Step the shadow state for one accepted sample and queue the command it issues
	task automatic predict_command(input logic act, input logic signed [ANGLE_W-1:0] ang,
		input logic signed [RATE_W-1:0] rt);
		int a_mag;
		int r_mag;
		logic issue;
		motor_cmd_t cmd;
		if (!act) return;
		a_mag = (ang < 0) ? -int'(ang) : int'(ang);
		r_mag = (rt < 0) ? -int'(rt) : int'(rt);
		if (a_mag > ANG_MAG_MAX) a_mag = ANG_MAG_MAX;
		if (r_mag > RATE_MAG_MAX) r_mag = RATE_MAG_MAX;
		issue = 1'b0;
		case (phase_shadow)
		PH_INIT: begin
			if (a_mag >= ANG_AT_BOTTOM && r_mag < RATE_SLOW_LIM) phase_shadow = PH_DOWN;
		end
		PH_DOWN: begin
			if (a_mag <= ANG_OFF_BOTTOM && r_mag <= RATE_STILL_MAX) begin
				phase_shadow = PH_LOW;
			end else begin
				dir_shadow = DIR_FWD;
				issue = 1'b1;
			end
		end
		PH_LOW: begin
			if (a_mag < ANG_SWING_HIGH) phase_shadow = PH_HIGH;
			dir_shadow = (rt > 0) ? DIR_BWD : DIR_FWD;
			issue = 1'b1;
		end
		default: begin
			if (a_mag < ANG_SWING_HIGH && r_mag < RATE_SLOW_LIM) locked_shadow = 1'b0;
			if (a_mag > ANG_NEAR_BOTTOM && r_mag > RATE_FAST_LIM && !locked_shadow) begin
				if (dir_shadow == DIR_FWD) dir_shadow = DIR_BWD;
				else if (dir_shadow == DIR_BWD) dir_shadow = DIR_FWD;
				locked_shadow = 1'b1;
				reversal_count++;
			end
			issue = (dir_shadow == DIR_FWD || dir_shadow == DIR_BWD);
		end
		endcase
		if (issue) begin
			if (dir_shadow == DIR_FWD) cmd.drive = DRIVE_W'(speed_shadow);
			else cmd.drive = DRIVE_W'(0) - DRIVE_W'(speed_shadow);
			cmd.phase = phase_shadow;
			pending_cmds.push_back(cmd);
		end
	endtask

	// Sender pacing: bursts of random length, random gaps between them
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_sample(input logic act, input logic signed [ANGLE_W-1:0] ang,
		input logic signed [RATE_W-1:0] rt);
		pace();
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= IN_W'({rt, ang});
		do @(posedge clk); while (!s_tready);
		predict_command(act, ang, rt);
		sent_count++;
		@(negedge clk);
	endtask

	// Write max_speed once every command has come out and the pipeline is empty
	task automatic set_max_speed(input logic [SPEED_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		speed_shadow = value;
		speed_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Resting at the bottom: only a slow sample near +-pi leaves init
	task automatic test_init_wait();
		set_max_speed(8'd255);
		send_sample(1'b0, 15'sd12868, 16'sd0);
		send_sample(1'b1, -15'sd12868, -16'sd32768);
		send_sample(1'b1, 15'sd0, 16'sd32767);
		send_sample(1'b1, 15'sd12779, 16'sd0);
		send_sample(1'b1, -15'sd12780, 16'sd511);
	endtask

	// Kick forward until off the bottom and nearly still
	task automatic test_down_kick();
		send_sample(1'b1, 15'sd12868, 16'sd0);
		send_sample(1'b0, 15'sd0, 16'sd0);
		send_sample(1'b1, 15'sd0, -16'sd52);
		send_sample(1'b1, -15'sd12779, 16'sd51);
	endtask

	// Pump against the rate until the swing gets high
	task automatic test_low_pump();
		send_sample(1'b1, 15'sd12868, 16'sd1);
		send_sample(1'b1, -15'sd12868, 16'sd0);
		send_sample(1'b0, 15'sd100, 16'sd100);
		send_sample(1'b1, 15'sd8192, -16'sd32768);
		send_sample(1'b1, -15'sd8191, 16'sd32767);
	endtask

	// Reverse once per lap: unlock up high and slow, flip at the bottom and fast
	task automatic test_high_reversal();
		set_max_speed(8'd1);
		send_sample(1'b1, 15'sd12868, -16'sd32768);
		send_sample(1'b1, 15'sd8191, 16'sd511);
		send_sample(1'b1, 15'sd12288, 16'sd4000);
		send_sample(1'b1, -15'sd12289, 16'sd2048);
		send_sample(1'b1, 15'sd12289, -16'sd2049);
		send_sample(1'b1, 15'sd12868, 16'sd32767);
		send_sample(1'b1, 15'sd0, 16'sd0);
		send_sample(1'b0, 15'sd12868, 16'sd32767);
		send_sample(1'b1, -15'sd12868, -16'sd32768);
		set_max_speed(8'd0);
		send_sample(1'b1, 15'sd100, 16'sd100);
	endtask

	// One random sample, mostly laps of the swing with noise and edge values mixed in
	task automatic random_sample();
		int pick;
		int a_mag;
		int r_mag;
		logic act;
		logic signed [ANGLE_W-1:0] ang;
		logic signed [RATE_W-1:0] rt;
		int ang_edges[8] = '{0, 8191, 8192, 12288, 12289, 12779, 12780, 12868};
		int rate_edges[8] = '{0, 51, 52, 511, 512, 2048, 2049, 32767};
		pick = $urandom_range(0, 99);
		act = 1'b1;
		if (pick < 8) begin
			act = 1'b0;
			a_mag = $urandom_range(0, 12868);
			r_mag = $urandom_range(0, RATE_MAG_MAX);
		end else if (pick < 38) begin
			a_mag = $urandom_range(0, ANG_SWING_HIGH - 1);
			r_mag = $urandom_range(0, RATE_SLOW_LIM - 1);
		end else if (pick < 68) begin
			a_mag = $urandom_range(ANG_NEAR_BOTTOM + 1, 12868);
			r_mag = $urandom_range(RATE_FAST_LIM + 1, RATE_MAG_MAX);
		end else if (pick < 85) begin
			a_mag = $urandom_range(0, 12868);
			r_mag = $urandom_range(0, RATE_MAG_MAX);
		end else begin
			a_mag = ang_edges[$urandom_range(0, 7)];
			r_mag = rate_edges[$urandom_range(0, 7)];
		end
		ang = ANGLE_W'($urandom_range(0, 1) ? -a_mag : a_mag);
		rt = RATE_W'($urandom_range(0, 1) ? -r_mag : r_mag);
		// most negative rate, whose magnitude saturates
		if ($urandom_range(0, 15) == 0) rt = {1'b1, {(RATE_W-1){1'b0}}};
		send_sample(act, ang, rt);
	endtask

	// Random swinging under several drive magnitudes, extremes included
	task automatic test_random_swing();
		int fixed_speeds[6] = '{255, 0, 150, -1, 1, -1};
		logic [SPEED_W-1:0] value;
		for (int k = 0; k < 6; k++) begin
			value = (fixed_speeds[k] < 0) ? SPEED_W'($urandom_range(2, 254))
				: SPEED_W'(fixed_speeds[k]);
			set_max_speed(value);
			repeat (320) random_sample();
		end
	endtask

	initial begin
		// assert reset once every process waits on it
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_init_wait();
		test_down_kick();
		test_low_pump();
		test_high_reversal();
		test_random_swing();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Walked init, down-still, low and high swing with %0d samples and %0d commands,",
			sent_count, cmd_count);
		$display("%0d drive reversals, %0d max_speed writes, %0d mismatches.",
			reversal_count, speed_writes, error_count);
		if (error_count == 0) begin
			$display("tb_pendulum_swingup_phase_machine OK");
		end else begin
			$display("tb_pendulum_swingup_phase_machine NOT OK");
		end
		$finish;
	end

endmodule
